@@ sv/scp_pkg.sv @@
`timescale 1ns / 1ps
package scp_pkg;

  // coordinate and parameter widths
  localparam int COORD_BITS = 32;
  localparam int T_BITS     = 32;
  localparam int TW         = T_BITS + 1;

  // derived arithmetic widths
  localparam int DIF_W     = COORD_BITS + 1;
  localparam int PRD_W     = 2 * DIF_W;
  localparam int DOT_W     = PRD_W + 2;
  localparam int BIG_W     = 2 * DOT_W;
  localparam int NUM_W     = BIG_W + 1;
  localparam int TN_W      = DOT_W + TW + 2;
  localparam int DIV_STEPS = T_BITS + 1;
  localparam int SQ_W      = 2 * COORD_BITS + 4;
  localparam int ROOT_W    = COORD_BITS + 2;

  // queue between front and back
  localparam int QDEPTH = 8;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // request classes found by the front
  localparam logic [1:0] KIND_BOTH   = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_SECOND = 2'd2;
  localparam logic [1:0] KIND_GEN    = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_start_z;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] first_end_z;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_start_z;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
    logic signed [COORD_BITS-1:0] second_end_z;
  } scp_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_first_x;
    logic signed [COORD_BITS-1:0] near_first_y;
    logic signed [COORD_BITS-1:0] near_first_z;
    logic signed [COORD_BITS-1:0] near_second_x;
    logic signed [COORD_BITS-1:0] near_second_y;
    logic signed [COORD_BITS-1:0] near_second_z;
    logic        [COORD_BITS-1:0] gap_distance;
  } scp_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } pt_t;

  typedef struct packed {
    logic signed [DIF_W-1:0] x;
    logic signed [DIF_W-1:0] y;
    logic signed [DIF_W-1:0] z;
  } dv_t;

  typedef struct packed {
    pt_t a0;
    pt_t b0;
    dv_t d1;
    dv_t d2;
  } geom_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] a;
    logic signed [DOT_W-1:0] b;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] e;
    logic signed [DOT_W-1:0] f;
  } dots_t;

  typedef struct packed {
    geom_t      g;
    dots_t      k;
    logic [1:0] kind;
  } qent_t;

  typedef struct packed {
    qent_t         ent;
    logic [TW-1:0] s0;
    logic [1:0]    mode;
  } side_t;

endpackage

@@ sv/scp_front.sv @@
`timescale 1ns / 1ps
module scp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  scp_pkg::scp_in_t in_item,
  output logic            out_valid,
  output scp_pkg::qent_t  out_ent,
  output logic [1:0]      fly_cnt
);

  localparam int DW = scp_pkg::DIF_W;
  localparam int PW = scp_pkg::PRD_W;
  localparam int KW = scp_pkg::DOT_W;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
  } prod3_t;

  function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] p,
                                               input logic signed [DW-1:0] q);
    mul = PW'(p) * PW'(q);
  endfunction

  function automatic logic signed [KW-1:0] dot(input prod3_t p);
    dot = KW'(p.x) + KW'(p.y) + KW'(p.z);
  endfunction

  logic           v1_r, v2_r, v3_r;
  scp_pkg::geom_t g1_r, g2_r;
  scp_pkg::dv_t   r1_r;
  prod3_t         aa_r, ee_r, bb_r, cc_r, ff_r;
  scp_pkg::qent_t ent_r;
  logic signed [KW-1:0] a_nxt, e_nxt;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: edge and offset vectors
  always_ff @(posedge clk) begin
    g1_r.a0.x <= in_item.first_start_x;
    g1_r.a0.y <= in_item.first_start_y;
    g1_r.a0.z <= in_item.first_start_z;
    g1_r.b0.x <= in_item.second_start_x;
    g1_r.b0.y <= in_item.second_start_y;
    g1_r.b0.z <= in_item.second_start_z;
    g1_r.d1.x <= DW'(in_item.first_end_x) - DW'(in_item.first_start_x);
    g1_r.d1.y <= DW'(in_item.first_end_y) - DW'(in_item.first_start_y);
    g1_r.d1.z <= DW'(in_item.first_end_z) - DW'(in_item.first_start_z);
    g1_r.d2.x <= DW'(in_item.second_end_x) - DW'(in_item.second_start_x);
    g1_r.d2.y <= DW'(in_item.second_end_y) - DW'(in_item.second_start_y);
    g1_r.d2.z <= DW'(in_item.second_end_z) - DW'(in_item.second_start_z);
    r1_r.x    <= DW'(in_item.first_start_x) - DW'(in_item.second_start_x);
    r1_r.y    <= DW'(in_item.first_start_y) - DW'(in_item.second_start_y);
    r1_r.z    <= DW'(in_item.first_start_z) - DW'(in_item.second_start_z);
  end

  // stage 2: per-axis products
  always_ff @(posedge clk) begin
    g2_r   <= g1_r;
    aa_r.x <= mul(g1_r.d1.x, g1_r.d1.x);
    aa_r.y <= mul(g1_r.d1.y, g1_r.d1.y);
    aa_r.z <= mul(g1_r.d1.z, g1_r.d1.z);
    ee_r.x <= mul(g1_r.d2.x, g1_r.d2.x);
    ee_r.y <= mul(g1_r.d2.y, g1_r.d2.y);
    ee_r.z <= mul(g1_r.d2.z, g1_r.d2.z);
    bb_r.x <= mul(g1_r.d1.x, g1_r.d2.x);
    bb_r.y <= mul(g1_r.d1.y, g1_r.d2.y);
    bb_r.z <= mul(g1_r.d1.z, g1_r.d2.z);
    cc_r.x <= mul(g1_r.d1.x, r1_r.x);
    cc_r.y <= mul(g1_r.d1.y, r1_r.y);
    cc_r.z <= mul(g1_r.d1.z, r1_r.z);
    ff_r.x <= mul(g1_r.d2.x, r1_r.x);
    ff_r.y <= mul(g1_r.d2.y, r1_r.y);
    ff_r.z <= mul(g1_r.d2.z, r1_r.z);
  end

  // stage 3: dot products and classification
  assign a_nxt = dot(aa_r);
  assign e_nxt = dot(ee_r);

  always_ff @(posedge clk) begin
    ent_r.g   <= g2_r;
    ent_r.k.a <= a_nxt;
    ent_r.k.e <= e_nxt;
    ent_r.k.b <= dot(bb_r);
    ent_r.k.c <= dot(cc_r);
    ent_r.k.f <= dot(ff_r);
    if (a_nxt == '0 && e_nxt == '0) begin
      ent_r.kind <= scp_pkg::KIND_BOTH;
    end else if (a_nxt == '0) begin
      ent_r.kind <= scp_pkg::KIND_FIRST;
    end else if (e_nxt == '0) begin
      ent_r.kind <= scp_pkg::KIND_SECOND;
    end else begin
      ent_r.kind <= scp_pkg::KIND_GEN;
    end
  end

  assign out_valid = v3_r;
  assign out_ent   = ent_r;
  assign fly_cnt   = 2'(v1_r) + 2'(v2_r) + 2'(v3_r);

endmodule

@@ sv/scp_queue.sv @@
`timescale 1ns / 1ps
module scp_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  scp_pkg::qent_t               push_ent,
  input  logic                         pop,
  output logic                         head_valid,
  output scp_pkg::qent_t               head_ent,
  output logic [scp_pkg::QCNT_W-1:0]   cnt
);

  localparam int DEPTH = scp_pkg::QDEPTH;
  localparam int AW    = $clog2(DEPTH);

  scp_pkg::qent_t              mem [0:DEPTH-1];
  logic [AW-1:0]               wr_ptr_r, rd_ptr_r;
  logic [scp_pkg::QCNT_W-1:0]  cnt_r;

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_ent;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + scp_pkg::QCNT_W'(push) - scp_pkg::QCNT_W'(pop);
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_ent   = mem[rd_ptr_r];
  assign cnt        = cnt_r;

endmodule

@@ sv/scp_div.sv @@
`timescale 1ns / 1ps
module scp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [scp_pkg::NUM_W-1:0]  num,
  input  logic signed [scp_pkg::NUM_W-1:0]  den,
  input  scp_pkg::side_t                    in_side,
  output logic                              out_valid,
  output logic [scp_pkg::TW-1:0]            quo,
  output scp_pkg::side_t                    out_side
);

  localparam int NW = scp_pkg::NUM_W;
  localparam int QW = scp_pkg::TW;
  localparam int NS = scp_pkg::DIV_STEPS;

  localparam logic [1:0] RM_ZERO = 2'd0;
  localparam logic [1:0] RM_ONE  = 2'd1;
  localparam logic [1:0] RM_DIV  = 2'd2;

  logic                 vld_r  [0:NS];
  logic [NW-1:0]        rem_r  [0:NS];
  logic [NW-1:0]        den_r  [0:NS];
  logic [QW-1:0]        q_r    [0:NS];
  logic [1:0]           mode_r [0:NS];
  scp_pkg::side_t       side_r [0:NS];
  logic [1:0]           mode_nxt;
  logic [QW:0]          inc;

  // clamp check ahead of the division
  always_comb begin
    if (num[NW-1] || num == '0) begin
      mode_nxt = RM_ZERO;
    end else if (num >= den) begin
      mode_nxt = RM_ONE;
    end else begin
      mode_nxt = RM_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      mode_r[0] <= mode_nxt;
      side_r[0] <= in_side;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [NW:0] dbl;
    logic [NW:0] dif;
    logic        fits;

    assign dbl  = {rem_r[k-1], 1'b0};
    assign dif  = dbl - {1'b0, den_r[k-1]};
    assign fits = !dif[NW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? dif[NW-1:0] : dbl[NW-1:0];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][QW-2:0], fits};
        mode_r[k] <= mode_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // round half up from the extra quotient bit
  assign inc = {1'b0, q_r[NS]} + 1'b1;

  always_comb begin
    case (mode_r[NS])
      RM_ZERO: quo = '0;
      RM_ONE:  quo = {1'b1, {(QW-1){1'b0}}};
      RM_DIV:  quo = inc[QW:1];
      default: quo = '0;
    endcase
  end

  assign out_valid = vld_r[NS];
  assign out_side  = side_r[NS];

endmodule

@@ sv/scp_back.sv @@
`timescale 1ns / 1ps
module scp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  scp_pkg::qent_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output scp_pkg::scp_out_t out_item
);

  localparam int CB  = scp_pkg::COORD_BITS;
  localparam int TB  = scp_pkg::T_BITS;
  localparam int TW  = scp_pkg::TW;
  localparam int DW  = scp_pkg::DIF_W;
  localparam int PW  = scp_pkg::PRD_W;
  localparam int KW  = scp_pkg::DOT_W;
  localparam int HW  = KW / 2;
  localparam int PPW = 2 * HW + 2;
  localparam int TPW = HW + TW + 2;
  localparam int BW  = scp_pkg::BIG_W;
  localparam int NW  = scp_pkg::NUM_W;
  localparam int TN  = scp_pkg::TN_W;
  localparam int MW  = TW + 1 + DW;
  localparam int SW  = scp_pkg::SQ_W;
  localparam int RW  = scp_pkg::ROOT_W;

  // how the two parameters come out of the second division
  localparam logic [1:0] M_T_S0 = 2'd0;
  localparam logic [1:0] M_T_SZ = 2'd1;
  localparam logic [1:0] M_S_T0 = 2'd2;
  localparam logic [1:0] M_S_T1 = 2'd3;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    logic signed [MW-1:0] z;
  } mv_t;

  typedef struct packed {
    scp_pkg::pt_t p1;
    scp_pkg::pt_t p2;
  } pair_t;

  // half-width partial products of one wide product
  typedef struct packed {
    logic signed [PPW-1:0] hh;
    logic signed [PPW-1:0] hl;
    logic signed [PPW-1:0] lh;
    logic signed [PPW-1:0] ll;
  } pp_t;

  function automatic logic signed [CB-1:0] along(input logic signed [CB-1:0] p0,
                                                 input logic signed [MW-1:0] prod);
    logic signed [MW-1:0] rnd;
    rnd   = (prod + (MW'(1) <<< (TB - 1))) >>> TB;
    along = CB'(MW'(p0) + rnd);
  endfunction

  function automatic logic signed [MW-1:0] scale(input logic [TW-1:0] prm,
                                                 input logic signed [DW-1:0] d);
    scale = MW'($signed({1'b0, prm})) * MW'(d);
  endfunction

  function automatic logic [PW-1:0] sqr(input logic signed [CB-1:0] p,
                                        input logic signed [CB-1:0] q);
    logic signed [PW-1:0] dd;
    dd  = PW'(p) - PW'(q);
    sqr = dd * dd;
  endfunction

  // signed upper half and unsigned lower half of each operand
  function automatic pp_t part_mul(input logic signed [KW-1:0] x,
                                   input logic signed [KW-1:0] y);
    logic signed [HW:0] xh, xl, yh, yl;
    xh = (HW+1)'($signed(x[KW-1:HW]));
    xl = $signed({1'b0, x[HW-1:0]});
    yh = (HW+1)'($signed(y[KW-1:HW]));
    yl = $signed({1'b0, y[HW-1:0]});
    part_mul.hh = PPW'(xh) * PPW'(yh);
    part_mul.hl = PPW'(xh) * PPW'(yl);
    part_mul.lh = PPW'(xl) * PPW'(yh);
    part_mul.ll = PPW'(xl) * PPW'(yl);
  endfunction

  function automatic logic signed [BW-1:0] part_sum(input pp_t p);
    part_sum = (BW'(p.hh) <<< (2 * HW)) + ((BW'(p.hl) + BW'(p.lh)) <<< HW)
               + BW'(p.ll);
  endfunction

  logic en;
  logic out_valid_r;
  scp_pkg::scp_out_t out_item_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  // stage B1: take the queue head
  logic           v1_r;
  scp_pkg::qent_t e1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r <= q_head;
    end
  end

  // stage B2a: partial products for the first parameter
  logic           v2p_r;
  scp_pkg::qent_t e2p_r;
  pp_t            pae_r, pbb_r, pbf_r, pce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2p_r <= 1'b0;
    end else if (en) begin
      v2p_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2p_r <= e1_r;
      pae_r <= part_mul(e1_r.k.a, e1_r.k.e);
      pbb_r <= part_mul(e1_r.k.b, e1_r.k.b);
      pbf_r <= part_mul(e1_r.k.b, e1_r.k.f);
      pce_r <= part_mul(e1_r.k.c, e1_r.k.e);
    end
  end

  // stage B2b: wide products for the first parameter
  logic                 v2_r;
  scp_pkg::qent_t       e2_r;
  logic signed [BW-1:0] ae_r, bb_r, bf_r, ce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v2p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_r <= e2p_r;
      ae_r <= part_sum(pae_r);
      bb_r <= part_sum(pbb_r);
      bf_r <= part_sum(pbf_r);
      ce_r <= part_sum(pce_r);
    end
  end

  // first division: s clamped to [0, 1], zero when parallel or degenerate
  logic signed [NW-1:0] den1, num1, n1, d1;
  scp_pkg::side_t       side1;

  assign den1 = NW'(ae_r) - NW'(bb_r);
  assign num1 = NW'(bf_r) - NW'(ce_r);

  always_comb begin
    side1      = '0;
    side1.ent  = e2_r;
    if (e2_r.kind == scp_pkg::KIND_GEN && den1 != '0) begin
      n1 = num1;
      d1 = den1;
    end else begin
      n1 = '0;
      d1 = NW'(1);
    end
  end

  logic           v3;
  logic [TW-1:0]  s0_q;
  scp_pkg::side_t side3;

  scp_div u_div_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .num       (n1),
    .den       (d1),
    .in_side   (side1),
    .out_valid (v3),
    .quo       (s0_q),
    .out_side  (side3)
  );

  // stage B4a: partial products of b times s
  logic                  v4p_r;
  scp_pkg::side_t        side4p_r;
  logic signed [TPW-1:0] thi_r, tlo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4p_r <= 1'b0;
    end else if (en) begin
      v4p_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4p_r.ent  <= side3.ent;
      side4p_r.s0   <= s0_q;
      side4p_r.mode <= side3.mode;
      thi_r <= TPW'($signed(side3.ent.k.b[KW-1:HW])) * TPW'($signed({1'b0, s0_q}));
      tlo_r <= TPW'($signed({1'b0, side3.ent.k.b[HW-1:0]}))
               * TPW'($signed({1'b0, s0_q}));
    end
  end

  // stage B4b: numerator for t
  logic                 v4_r;
  scp_pkg::side_t       side4_r;
  logic signed [TN-1:0] tn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v4p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side4p_r;
      tn_r    <= (TN'(thi_r) <<< HW) + TN'(tlo_r) + (TN'(side4p_r.ent.k.f) <<< TB);
    end
  end

  // pick the second division by class and range of t
  logic signed [NW-1:0] ep, tnw, neg_c, bmc, n2, d2;
  scp_pkg::side_t       side5;

  assign ep    = NW'(side4_r.ent.k.e) <<< TB;
  assign tnw   = NW'(tn_r);
  assign neg_c = -NW'(side4_r.ent.k.c);
  assign bmc   = NW'(side4_r.ent.k.b) - NW'(side4_r.ent.k.c);

  always_comb begin
    side5 = side4_r;
    case (side4_r.ent.kind)
      scp_pkg::KIND_BOTH: begin
        n2         = '0;
        d2         = NW'(1);
        side5.mode = M_T_SZ;
      end
      scp_pkg::KIND_FIRST: begin
        n2         = NW'(side4_r.ent.k.f);
        d2         = NW'(side4_r.ent.k.e);
        side5.mode = M_T_SZ;
      end
      scp_pkg::KIND_SECOND: begin
        n2         = neg_c;
        d2         = NW'(side4_r.ent.k.a);
        side5.mode = M_S_T0;
      end
      scp_pkg::KIND_GEN: begin
        if (tnw < 0) begin
          n2         = neg_c;
          d2         = NW'(side4_r.ent.k.a);
          side5.mode = M_S_T0;
        end else if (tnw > ep) begin
          n2         = bmc;
          d2         = NW'(side4_r.ent.k.a);
          side5.mode = M_S_T1;
        end else begin
          n2         = tnw;
          d2         = ep;
          side5.mode = M_T_S0;
        end
      end
      default: begin
        n2         = '0;
        d2         = NW'(1);
        side5.mode = M_T_SZ;
      end
    endcase
  end

  logic           v6;
  logic [TW-1:0]  q2;
  scp_pkg::side_t side6;

  scp_div u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .num       (n2),
    .den       (d2),
    .in_side   (side5),
    .out_valid (v6),
    .quo       (q2),
    .out_side  (side6)
  );

  // stage B6: final parameters scaled onto the edges
  logic [TW-1:0] s_fin, t_fin;

  always_comb begin
    case (side6.mode)
      M_T_S0: begin
        s_fin = side6.s0;
        t_fin = q2;
      end
      M_T_SZ: begin
        s_fin = '0;
        t_fin = q2;
      end
      M_S_T0: begin
        s_fin = q2;
        t_fin = '0;
      end
      M_S_T1: begin
        s_fin = q2;
        t_fin = {1'b1, {(TW-1){1'b0}}};
      end
      default: begin
        s_fin = '0;
        t_fin = '0;
      end
    endcase
  end

  logic         v7_r;
  scp_pkg::pt_t a0_7_r, b0_7_r;
  mv_t          ma_r, mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_7_r <= side6.ent.g.a0;
      b0_7_r <= side6.ent.g.b0;
      ma_r.x <= scale(s_fin, side6.ent.g.d1.x);
      ma_r.y <= scale(s_fin, side6.ent.g.d1.y);
      ma_r.z <= scale(s_fin, side6.ent.g.d1.z);
      mb_r.x <= scale(t_fin, side6.ent.g.d2.x);
      mb_r.y <= scale(t_fin, side6.ent.g.d2.y);
      mb_r.z <= scale(t_fin, side6.ent.g.d2.z);
    end
  end

  // stage B7: closest points
  logic  v8_r;
  pair_t pt8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt8_r.p1.x <= along(a0_7_r.x, ma_r.x);
      pt8_r.p1.y <= along(a0_7_r.y, ma_r.y);
      pt8_r.p1.z <= along(a0_7_r.z, ma_r.z);
      pt8_r.p2.x <= along(b0_7_r.x, mb_r.x);
      pt8_r.p2.y <= along(b0_7_r.y, mb_r.y);
      pt8_r.p2.z <= along(b0_7_r.z, mb_r.z);
    end
  end

  // stage B8: squared gaps per axis
  logic          v9_r;
  pair_t         pt9_r;
  logic [PW-1:0] sqx_r, sqy_r, sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt9_r <= pt8_r;
      sqx_r <= sqr(pt8_r.p1.x, pt8_r.p2.x);
      sqy_r <= sqr(pt8_r.p1.y, pt8_r.p2.y);
      sqz_r <= sqr(pt8_r.p1.z, pt8_r.p2.z);
    end
  end

  // stage B9 and square root, one root bit per stage
  logic          rv_r   [0:RW];
  pair_t         rpt_r  [0:RW];
  logic [SW-1:0] rsum_r [0:RW];
  logic [SW-1:0] rsq_r  [0:RW];
  logic [RW-1:0] root_r [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rpt_r[0]  <= pt9_r;
      rsum_r[0] <= SW'(sqx_r) + SW'(sqy_r) + SW'(sqz_r);
      rsq_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= RW; j++) begin : g_root
    localparam int K = RW - j;
    logic [SW:0] cand;
    logic        take_bit;

    assign cand     = (SW+1)'(rsq_r[j-1]) + ((SW+1)'(root_r[j-1]) << (K + 1))
                      + ((SW+1)'(1) << (2 * K));
    assign take_bit = cand <= (SW+1)'(rsum_r[j-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[j] <= 1'b0;
      end else if (en) begin
        rv_r[j] <= rv_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rpt_r[j]  <= rpt_r[j-1];
        rsum_r[j] <= rsum_r[j-1];
        rsq_r[j]  <= take_bit ? cand[SW-1:0] : rsq_r[j-1];
        root_r[j] <= root_r[j-1] | (take_bit ? (RW'(1) << K) : '0);
      end
    end
  end

  // output register with saturated distance
  logic [CB-1:0] gap;

  assign gap = (root_r[RW][RW-1:CB] != '0) ? '1 : root_r[RW][CB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rv_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r.near_first_x  <= rpt_r[RW].p1.x;
      out_item_r.near_first_y  <= rpt_r[RW].p1.y;
      out_item_r.near_first_z  <= rpt_r[RW].p1.z;
      out_item_r.near_second_x <= rpt_r[RW].p2.x;
      out_item_r.near_second_y <= rpt_r[RW].p2.y;
      out_item_r.near_second_z <= rpt_r[RW].p2.z;
      out_item_r.gap_distance  <= gap;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sv/segment_segment_closest_points.sv @@
// Pipeline at 32-bit coordinates: 3 front stages, queue, head register, 2 product
// stages, two 34-stage dividers, 2 stages for the t numerator, 3 point and distance
// stages, a 35-stage square root and the output register. The back stalls as a
// whole while a result waits. Throughput: one request per cycle while out_ready is
// high; dividers and square root are fully pipelined.
// Reset: synchronous active-low rst_n clears all valid bits and the queue.
`timescale 1ns / 1ps
module segment_segment_closest_points (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scp_pkg::scp_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output scp_pkg::scp_out_t out_item
);

  localparam int CW = scp_pkg::QCNT_W;

  logic                  take;
  logic                  f_valid;
  scp_pkg::qent_t        f_ent;
  logic [1:0]            fly_cnt;
  logic                  q_valid;
  scp_pkg::qent_t        q_head;
  logic                  q_pop;
  logic [CW-1:0]         q_cnt;

  // credit check: queue plus front stages never exceed the queue depth
  assign in_ready = ((CW+1)'(q_cnt) + (CW+1)'(fly_cnt)) < (CW+1)'(scp_pkg::QDEPTH);
  assign take     = in_valid && in_ready;

  scp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_item   (in_item),
    .out_valid (f_valid),
    .out_ent   (f_ent),
    .fly_cnt   (fly_cnt)
  );

  scp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_ent   (f_ent),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_ent   (q_head),
    .cnt        (q_cnt)
  );

  scp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // queue never written while full unless it is popped in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid |-> (q_cnt < CW'(scp_pkg::QDEPTH)) || q_pop)
    else $error("queue overflow");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_cnt != '0))
    else $error("queue underflow");

  // an accepted request reaches f_valid once it has passed the front stages
  a_front_flow: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##3 f_valid)
    else $error("front lost a request");

endmodule
